// ===== rtl/wsc_pkg.sv =====
package wsc_pkg;

    // transaction field widths
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 8;
    localparam int DATA_W   = 8;
    localparam int SAMPLE_W = 4;

    // internal state widths
    localparam int FREQ_W  = 11;
    localparam int TIMER_W = 12;
    localparam int LEN_W   = 9;
    localparam int VOL_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_REG_RD = 3'd1;
    localparam logic [OP_W-1:0] OP_REG_WR = 3'd2;
    localparam logic [OP_W-1:0] OP_PAT_RD = 3'd3;
    localparam logic [OP_W-1:0] OP_PAT_WR = 3'd4;

    // register codes
    localparam logic [ADDR_W-1:0] REG_DAC  = 8'h1A;
    localparam logic [ADDR_W-1:0] REG_LEN  = 8'h1B;
    localparam logic [ADDR_W-1:0] REG_VOL  = 8'h1C;
    localparam logic [ADDR_W-1:0] REG_FLO  = 8'h1D;
    localparam logic [ADDR_W-1:0] REG_FHI  = 8'h1E;

    // read-back masks
    localparam logic [DATA_W-1:0] MASK_DAC = 8'h7F;
    localparam logic [DATA_W-1:0] MASK_VOL = 8'h9F;
    localparam logic [DATA_W-1:0] MASK_FHI = 8'hBF;
    localparam logic [DATA_W-1:0] READ_FF  = 8'hFF;

    localparam logic [LEN_W-1:0]   LEN_FULL  = 9'd256;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 12'hFFF;

    // period reload: (2048 - f) * 2, saturated to the timer width
    function automatic logic [TIMER_W-1:0] period_reload(input logic [FREQ_W-1:0] freq);
        logic [FREQ_W-1:0] neg;
        neg = FREQ_W'(0) - freq;
        if (freq == '0) begin
            period_reload = TIMER_MAX;
        end else begin
            period_reload = {neg, 1'b0};
        end
    endfunction

endpackage

// ===== rtl/wsc_in_if.sv =====
interface wsc_in_if;
    logic                         valid;
    logic                         ready;
    logic [wsc_pkg::OP_W-1:0]     operation;
    logic [wsc_pkg::ADDR_W-1:0]   address;
    logic [wsc_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

// ===== rtl/wsc_out_if.sv =====
interface wsc_out_if;
    logic                           valid;
    logic                           ready;
    logic [wsc_pkg::DATA_W-1:0]     read_data;
    logic [wsc_pkg::SAMPLE_W-1:0]   sample_out;
    logic                           channel_active;

    modport source (output valid, output read_data, output sample_out, output channel_active,
                    input ready);
    modport sink   (input valid, input read_data, input sample_out, input channel_active,
                    output ready);
endinterface

// ===== rtl/wsc_ram.sv =====
module wsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wavetable_sound_channel.sv =====
// A result passes through the pattern RAM registered read (stage 1), then the output
//   register.
// Throughput: one transaction per cycle, sustained while the output side takes results.
// Reset (synchronous, active low) clears timer, position, registers, held sample and
//   pipeline valids, and sets power on; the pattern RAM is not cleared.
module wavetable_sound_channel #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    wsc_in_if.sink     i_in,
    wsc_out_if.source  o_out
);

    localparam int AW = $clog2(PATTERN_BYTES);
    localparam int PW = AW + 1;

    // channel state
    logic                              r_power, n_power;
    logic [PW-1:0]                     r_pos, n_pos;
    logic [wsc_pkg::TIMER_W-1:0]       r_timer, n_timer;
    logic [wsc_pkg::FREQ_W-1:0]        r_freq, n_freq;
    logic [wsc_pkg::VOL_W-1:0]         r_vol, n_vol;
    logic                              r_dac, n_dac;
    logic                              r_active, n_active;
    logic [wsc_pkg::LEN_W-1:0]         r_len, n_len;
    logic                              r_len_en, n_len_en;
    logic [wsc_pkg::SAMPLE_W-1:0]      r_held, n_held;

    // stage 1 (waiting on RAM read data)
    logic                              r_s1_valid;
    logic                              r_s1_tick;
    logic                              r_s1_pat_rd;
    logic [wsc_pkg::DATA_W-1:0]        r_s1_rd;
    logic [wsc_pkg::VOL_W-1:0]         r_s1_vol;
    logic                              r_s1_nib_hi;
    logic                              r_s1_active;

    // output register
    logic                              r_o_valid;
    logic [wsc_pkg::DATA_W-1:0]        r_o_rd;
    logic [wsc_pkg::SAMPLE_W-1:0]      r_o_sample;
    logic                              r_o_active;

    logic                              w_accept;
    logic                              w_s1_adv;
    logic [wsc_pkg::DATA_W-1:0]        w_reg_rd;
    logic [AW-1:0]                     w_ram_addr;
    logic [wsc_pkg::DATA_W-1:0]        w_ram_rdata;
    logic [wsc_pkg::SAMPLE_W-1:0]      w_nib;
    logic [wsc_pkg::SAMPLE_W-1:0]      w_shifted;

    // handshake: stage 1 moves on when the output register is free or being taken
    assign w_s1_adv   = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_accept   = i_in.valid && i_in.ready;

    // configuration
    always_comb begin
        n_power = r_power;
        if (i_cfg_we) begin
            n_power = i_cfg_wdata;
        end
    end

    // register read-back
    always_comb begin
        unique case (i_in.address)
            wsc_pkg::REG_DAC: w_reg_rd = {r_dac, 7'd0} | wsc_pkg::MASK_DAC;
            wsc_pkg::REG_VOL: w_reg_rd = {1'b0, r_vol, 5'd0} | wsc_pkg::MASK_VOL;
            wsc_pkg::REG_FHI: w_reg_rd = {1'b0, r_len_en, 6'd0} | wsc_pkg::MASK_FHI;
            default:          w_reg_rd = wsc_pkg::READ_FF;
        endcase
    end

    // channel state update for an accepted transaction
    always_comb begin
        n_pos    = r_pos;
        n_timer  = r_timer;
        n_freq   = r_freq;
        n_vol    = r_vol;
        n_dac    = r_dac;
        n_active = r_active;
        n_len    = r_len;
        n_len_en = r_len_en;
        if (w_accept) begin
            unique case (i_in.operation)
                wsc_pkg::OP_TICK: begin
                    if (r_timer != '0) begin
                        n_timer = r_timer - 1'b1;
                        if (r_timer == wsc_pkg::TIMER_W'(1)) begin
                            n_timer = wsc_pkg::period_reload(r_freq);
                            n_pos   = r_pos + 1'b1;
                        end
                    end
                end
                wsc_pkg::OP_REG_WR: begin
                    if (r_power || i_in.address == wsc_pkg::REG_LEN) begin
                        unique case (i_in.address)
                            wsc_pkg::REG_DAC: begin
                                n_dac = i_in.write_data[7];
                                if (!i_in.write_data[7]) begin
                                    n_active = 1'b0;
                                end
                            end
                            wsc_pkg::REG_LEN: begin
                                n_len = wsc_pkg::LEN_FULL - {1'b0, i_in.write_data};
                            end
                            wsc_pkg::REG_VOL: begin
                                n_vol = i_in.write_data[6:5];
                            end
                            wsc_pkg::REG_FLO: begin
                                n_freq[7:0] = i_in.write_data;
                            end
                            wsc_pkg::REG_FHI: begin
                                n_freq[10:8] = i_in.write_data[2:0];
                                n_len_en     = i_in.write_data[6];
                                // trigger
                                if (i_in.write_data[7]) begin
                                    if (r_dac) begin
                                        n_active = 1'b1;
                                    end
                                    if (r_len == '0) begin
                                        n_len    = wsc_pkg::LEN_FULL;
                                        n_len_en = 1'b0;
                                    end
                                    n_timer = wsc_pkg::period_reload(
                                        {i_in.write_data[2:0], r_freq[7:0]});
                                    n_pos   = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // pattern RAM: ticks read the byte at the new position, otherwise the bus offset
    assign w_ram_addr = (i_in.operation == wsc_pkg::OP_TICK) ? n_pos[PW-1:1]
                                                             : i_in.address[AW-1:0];

    wsc_ram #(
        .WIDTH (wsc_pkg::DATA_W),
        .DEPTH (PATTERN_BYTES)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_in.operation == wsc_pkg::OP_PAT_WR),
        .i_re    (w_accept),
        .i_addr  (w_ram_addr),
        .i_wdata (i_in.write_data),
        .o_rdata (w_ram_rdata)
    );

    // nibble select and volume shift; code zero mutes
    assign w_nib = r_s1_nib_hi ? w_ram_rdata[7:4] : w_ram_rdata[3:0];
    always_comb begin
        unique case (r_s1_vol)
            2'd0:    w_shifted = '0;
            2'd1:    w_shifted = w_nib;
            2'd2:    w_shifted = w_nib >> 1;
            default: w_shifted = w_nib >> 2;
        endcase
    end

    always_comb begin
        n_held = r_held;
        if (w_s1_adv && r_s1_tick) begin
            n_held = w_shifted;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power    <= 1'b1;
            r_pos      <= '0;
            r_timer    <= '0;
            r_freq     <= '0;
            r_vol      <= '0;
            r_dac      <= 1'b0;
            r_active   <= 1'b0;
            r_len      <= '0;
            r_len_en   <= 1'b0;
            r_held     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_power    <= n_power;
            r_pos      <= n_pos;
            r_timer    <= n_timer;
            r_freq     <= n_freq;
            r_vol      <= n_vol;
            r_dac      <= n_dac;
            r_active   <= n_active;
            r_len      <= n_len;
            r_len_en   <= n_len_en;
            r_held     <= n_held;
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_tick   <= (i_in.operation == wsc_pkg::OP_TICK);
            r_s1_pat_rd <= (i_in.operation == wsc_pkg::OP_PAT_RD);
            r_s1_rd     <= (i_in.operation == wsc_pkg::OP_REG_RD) ? w_reg_rd : '0;
            r_s1_vol    <= r_vol;
            r_s1_nib_hi <= n_pos[0];
            r_s1_active <= n_active;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_o_rd     <= r_s1_pat_rd ? w_ram_rdata : r_s1_rd;
            r_o_sample <= n_held;
            r_o_active <= r_s1_active;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.read_data      = r_o_rd;
    assign o_out.sample_out     = r_o_sample;
    assign o_out.channel_active = r_o_active;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAT_BYTES = 16;
    // highest operation code; everything above OP_PAT_WR is unused
    localparam logic [wsc_pkg::OP_W-1:0] OP_LAST = '1;

    typedef struct packed {
        logic [wsc_pkg::OP_W-1:0]   op;
        logic [wsc_pkg::ADDR_W-1:0] addr;
        logic [wsc_pkg::DATA_W-1:0] data;
    } t_bus_txn;

    typedef struct packed {
        logic [wsc_pkg::DATA_W-1:0]   rd;
        logic [wsc_pkg::SAMPLE_W-1:0] sample;
        logic                         active;
    } t_chan_out;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    wsc_in_if  in_if ();
    wsc_out_if out_if ();

    wavetable_sound_channel #(.PATTERN_BYTES(PAT_BYTES)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // pending bus transactions and predicted channel outputs
    t_bus_txn  bus_q[$];
    t_chan_out chan_q[$];

    int queued;
    int err_count;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_left;
    logic in_fire;

    // channel state as predicted
    logic [wsc_pkg::DATA_W-1:0]   ch_pat [PAT_BYTES];
    logic [4:0]                   ch_pos;
    logic [wsc_pkg::TIMER_W-1:0]  ch_timer;
    logic [wsc_pkg::FREQ_W-1:0]   ch_freq;
    logic [wsc_pkg::VOL_W-1:0]    ch_vol;
    logic                         ch_dac;
    logic                         ch_active;
    logic [wsc_pkg::LEN_W-1:0]    ch_len;
    logic                         ch_len_en;
    logic [wsc_pkg::SAMPLE_W-1:0] ch_held;
    logic                         ch_power;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        err_count++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    endtask

    // period reload, (2048 - f) * 2 clipped to the timer width
    function automatic logic [wsc_pkg::TIMER_W-1:0] period_of(
        input logic [wsc_pkg::FREQ_W-1:0] f);
        int r;
        r = (2048 - int'(f)) * 2;
        if (r > int'(wsc_pkg::TIMER_MAX)) begin
            r = int'(wsc_pkg::TIMER_MAX);
        end
        return wsc_pkg::TIMER_W'(r);
    endfunction

    function automatic logic [wsc_pkg::DATA_W-1:0] reg_value(
        input logic [wsc_pkg::ADDR_W-1:0] a);
        case (a)
            wsc_pkg::REG_DAC: return {ch_dac, 7'b0} | wsc_pkg::MASK_DAC;
            wsc_pkg::REG_VOL: return {1'b0, ch_vol, 5'b0} | wsc_pkg::MASK_VOL;
            wsc_pkg::REG_FHI: return {1'b0, ch_len_en, 6'b0} | wsc_pkg::MASK_FHI;
            default:          return wsc_pkg::READ_FF;
        endcase
    endfunction

    task automatic reg_store(input logic [wsc_pkg::ADDR_W-1:0] a,
                             input logic [wsc_pkg::DATA_W-1:0] d);
        // power off blocks everything but the length load
        if (!ch_power && a != wsc_pkg::REG_LEN) begin
            return;
        end
        case (a)
            wsc_pkg::REG_DAC: begin
                ch_dac = d[7];
                if (!d[7]) begin
                    ch_active = 1'b0;
                end
            end
            wsc_pkg::REG_LEN: ch_len = wsc_pkg::LEN_FULL - wsc_pkg::LEN_W'(d);
            wsc_pkg::REG_VOL: ch_vol = d[6:5];
            wsc_pkg::REG_FLO: ch_freq[7:0] = d;
            wsc_pkg::REG_FHI: begin
                ch_freq[10:8] = d[2:0];
                ch_len_en = d[6];
                // trigger
                if (d[7]) begin
                    if (ch_dac) begin
                        ch_active = 1'b1;
                    end
                    if (ch_len == '0) begin
                        ch_len = wsc_pkg::LEN_FULL;
                        ch_len_en = 1'b0;
                    end
                    ch_timer = period_of(ch_freq);
                    ch_pos = '0;
                end
            end
            default: ;
        endcase
    endtask

    // one accepted transaction: update the channel and queue its output
    task automatic channel_step(input t_bus_txn t);
        t_chan_out r;
        logic [wsc_pkg::DATA_W-1:0] b;
        logic [wsc_pkg::SAMPLE_W-1:0] nib;
        r = '0;
        case (t.op)
            wsc_pkg::OP_TICK: begin
                if (ch_timer != '0) begin
                    ch_timer = ch_timer - 1'b1;
                    if (ch_timer == '0) begin
                        ch_timer = period_of(ch_freq);
                        ch_pos = ch_pos + 1'b1;
                    end
                end
                b = ch_pat[ch_pos[4:1]];
                nib = ch_pos[0] ? b[7:4] : b[3:0];
                ch_held = (ch_vol == '0) ? '0 : (nib >> (ch_vol - 1'b1));
            end
            wsc_pkg::OP_REG_RD: r.rd = reg_value(t.addr);
            wsc_pkg::OP_REG_WR: reg_store(t.addr, t.data);
            wsc_pkg::OP_PAT_RD: r.rd = ch_pat[t.addr[3:0]];
            wsc_pkg::OP_PAT_WR: ch_pat[t.addr[3:0]] = t.data;
            default: ;
        endcase
        r.sample = ch_held;
        r.active = ch_active;
        chan_q.push_back(r);
    endtask

    // driver: next transaction goes out once the current one is taken
    always @(negedge i_clk) begin
        t_bus_txn nxt;
        if (!in_if.valid || in_fire) begin
            if (bus_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = bus_q.pop_front();
                in_if.valid      <= 1'b1;
                in_if.operation  <= nxt.op;
                in_if.address    <= nxt.addr;
                in_if.write_data <= nxt.data;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver stalls, with a long hold-off on request
    always @(negedge i_clk) begin
        out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: check results, then predict newly accepted transactions
    always @(posedge i_clk) begin
        t_chan_out want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (chan_q.size() == 0) begin
                    report_mismatch("unexpected result", int'(out_if.read_data), 0);
                end else begin
                    want = chan_q.pop_front();
                    if (out_if.read_data !== want.rd) begin
                        report_mismatch("read_data", int'(out_if.read_data), int'(want.rd));
                    end
                    if (out_if.sample_out !== want.sample) begin
                        report_mismatch("sample_out", int'(out_if.sample_out),
                                        int'(want.sample));
                    end
                    if (out_if.channel_active !== want.active) begin
                        report_mismatch("channel_active", int'(out_if.channel_active),
                                        int'(want.active));
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                channel_step(t_bus_txn'{in_if.operation, in_if.address, in_if.write_data});
            end
        end
    end

    task automatic push_txn(input logic [wsc_pkg::OP_W-1:0] op,
                            input logic [wsc_pkg::ADDR_W-1:0] a,
                            input logic [wsc_pkg::DATA_W-1:0] d);
        bus_q.push_back(t_bus_txn'{op, a, d});
        queued++;
    endtask

    // random byte leaning toward the extremes
    function automatic logic [wsc_pkg::DATA_W-1:0] pick_byte();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return wsc_pkg::DATA_W'($urandom);
        endcase
    endfunction

    task automatic push_noise();
        logic [wsc_pkg::ADDR_W-1:0] a;
        if ($urandom_range(1) != 0) begin
            a = wsc_pkg::ADDR_W'($urandom_range(wsc_pkg::REG_FHI, wsc_pkg::REG_DAC));
        end else begin
            a = wsc_pkg::ADDR_W'($urandom);
        end
        push_txn(wsc_pkg::OP_W'($urandom_range(OP_LAST, wsc_pkg::OP_TICK)), a, pick_byte());
    endtask

    // side traffic between ticks of a note
    task automatic push_aside();
        case ($urandom_range(4))
            0: push_txn(wsc_pkg::OP_REG_RD,
                        wsc_pkg::ADDR_W'($urandom_range(wsc_pkg::REG_FHI, wsc_pkg::REG_DAC)),
                        wsc_pkg::DATA_W'($urandom));
            1: push_txn(wsc_pkg::OP_PAT_RD, wsc_pkg::ADDR_W'($urandom),
                        wsc_pkg::DATA_W'($urandom));
            2: push_txn(wsc_pkg::OP_PAT_WR, wsc_pkg::ADDR_W'($urandom), pick_byte());
            3: push_txn(wsc_pkg::OP_W'($urandom_range(OP_LAST, wsc_pkg::OP_PAT_WR + 1)),
                        wsc_pkg::ADDR_W'($urandom), wsc_pkg::DATA_W'($urandom));
            default: push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_VOL,
                              wsc_pkg::DATA_W'($urandom));
        endcase
    endtask

    // set up the channel, trigger (most notes), then run ticks
    task automatic push_note();
        logic [wsc_pkg::DATA_W-1:0] flo;
        logic [2:0] fhi;
        logic trig;
        int ticks;
        ticks = $urandom_range(40, 6);
        trig = ($urandom_range(9) != 0);
        if ($urandom_range(15) == 0) begin
            // slowest period, reload clips
            flo = '0;
            fhi = '0;
        end else begin
            flo = $urandom_range(3) != 0 ? wsc_pkg::DATA_W'($urandom_range(8'hFF, 8'hF8))
                                         : pick_byte();
            fhi = $urandom_range(1) ? 3'b111 : 3'($urandom);
        end
        if ($urandom_range(1)) begin
            push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_LEN, pick_byte());
        end
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_DAC,
                 {1'($urandom_range(9) != 0), 7'($urandom)});
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_VOL, wsc_pkg::DATA_W'($urandom));
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_FLO, flo);
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_FHI, {trig, 4'($urandom), fhi});
        repeat (ticks) begin
            push_txn(wsc_pkg::OP_TICK, wsc_pkg::ADDR_W'($urandom),
                     wsc_pkg::DATA_W'($urandom));
            if ($urandom_range(99) < 15) begin
                push_aside();
            end
        end
    endtask

    task automatic fill_random(input int n);
        queued = 0;
        while (queued < n) begin
            if ($urandom_range(4) != 0) begin
                push_note();
            end else begin
                repeat ($urandom_range(6, 1)) push_noise();
            end
        end
    endtask

    task automatic push_directed();
        // fill the whole pattern first so no tick or read hits an unwritten byte
        for (int i = 0; i < PAT_BYTES; i++) begin
            push_txn(wsc_pkg::OP_PAT_WR, {4'($urandom), 4'(i)},
                     (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : wsc_pkg::DATA_W'($urandom));
        end
        push_txn(wsc_pkg::OP_TICK, '0, '0);                 // timer idle before any trigger
        push_txn(wsc_pkg::OP_REG_RD, 8'hFF, '0);            // unknown register
        push_txn(wsc_pkg::OP_REG_WR, 8'h00, 8'hFF);         // unknown register write, dropped
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_DAC, 8'h80);
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_VOL, 8'h60);
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_FLO, 8'hFF);
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_FHI, 8'hC7); // trigger with length zero
        push_txn(wsc_pkg::OP_REG_RD, wsc_pkg::REG_FHI, '0);
        push_txn(wsc_pkg::OP_TICK, '0, '0);
        push_txn(wsc_pkg::OP_TICK, '1, '1);
        push_txn(OP_LAST, '1, '1);                          // unused operation
        push_txn(wsc_pkg::OP_REG_WR, wsc_pkg::REG_VOL, 8'h00); // mute
        push_txn(wsc_pkg::OP_TICK, '0, '0);
    endtask

    // wait until every result is in, then let the pipeline settle
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (bus_q.size() != 0 || in_if.valid || chan_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_power(input logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        ch_power = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic power, input int src, input int snk, input int n,
                             input int hold, input bit split);
        write_power(power);
        src_idle_pct  <= src;
        snk_stall_pct <= snk;
        if (split) begin
            // sender stops until everything has drained, then resumes
            fill_random(n / 2);
            wait_idle();
            fill_random(n - n / 2);
        end else begin
            fill_random(n);
        end
        if (hold != 0) begin
            hold_left <= hold;
        end
        wait_idle();
    endtask

    // stimulus
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 1'b0;
        in_if.valid      = 1'b0;
        in_if.operation  = '0;
        in_if.address    = '0;
        in_if.write_data = '0;
        out_if.ready     = 1'b0;
        in_fire          = 1'b0;
        err_count        = 0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;
        hold_left        = 0;
        queued           = 0;
        ch_pos    = '0;
        ch_timer  = '0;
        ch_freq   = '0;
        ch_vol    = '0;
        ch_dac    = 1'b0;
        ch_active = 1'b0;
        ch_len    = '0;
        ch_len_en = 1'b0;
        ch_held   = '0;
        ch_power  = 1'b1;
        foreach (ch_pat[i]) ch_pat[i] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_power(1'b1);
        push_directed();
        wait_idle();

        run_phase(1'b1, 0, 0, 300, 120, 1'b0);
        run_phase(1'b0, 62, 0, 300, 0, 1'b1);
        run_phase(1'b1, 0, 62, 300, 0, 1'b0);
        run_phase(1'b0, 34, 34, 300, 0, 1'b0);
        run_phase(1'b1, 34, 34, 200, 0, 1'b0);
        run_phase(1'b1, 0, 0, 150, 0, 1'b0);

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
